// File: hdl/rlsp_pkg.sv
package rlsp_pkg;

  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 6;
  localparam int OP_W       = 3;
  localparam int PCT_W      = 7;
  localparam int MS_W       = 16;
  localparam int LEVEL_W    = 15;
  localparam int WORD_W     = 56;
  localparam int PROG_WORDS = 64;
  localparam int NUM_W      = 23;
  localparam int RES_MAX    = 64;
  localparam int RES_AW     = 6;
  localparam int RES_CNT_W  = 7;
  localparam int RES_W      = 3 * LEVEL_W;

  // program word layout
  localparam int W_R_LSB   = 3;
  localparam int W_G_LSB   = 10;
  localparam int W_B_LSB   = 17;
  localparam int W_DUR_LSB = 24;
  localparam int W_STP_LSB = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_code_t;

  typedef enum logic [OP_W-1:0] {
    OP_END   = 3'd0,
    OP_LOOP  = 3'd1,
    OP_SET   = 3'd2,
    OP_DELAY = 3'd3,
    OP_FADE  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    PUSH_WORD  = 2'd0,
    PUSH_HELD  = 2'd1,
    PUSH_LEVEL = 2'd2
  } push_src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESUME,
    S_FETCH,
    S_DECODE,
    S_CNT_DIV,
    S_FP_MUL,
    S_FP_DIV,
    S_FP_WAIT,
    S_FP_NEXT,
    S_FINISH,
    S_DR_READ,
    S_DR_OUT
  } state_t;

  typedef struct packed {
    logic      prog_wr;
    logic      start_seq;
    logic      tick_dec;
    logic      fade_adv;
    logic      fade_finish;
    logic      seq_advance;
    logic      fetch;
    logic      do_loop;
    logic      load_held;
    logic      pc_inc;
    logic      set_wait_dur;
    logic      set_halt;
    logic      set_stop;
    logic      fade_latch;
    logic      cnt_load;
    logic      fp_mul;
    logic      div_start;
    logic      level_bypass;
    logic      level_div;
    logic      ch_inc;
    logic      set_wait_step;
    logic      push;
    push_src_t push_src;
    logic      rd_issue;
    logic      rd_adv;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_hit;
    logic wait_one;
    logic fade_active;
    logic fade_more;
    logic guard_hit;
    op_t  op;
    logic dur_zero;
    logic stp_zero;
    logic div_done;
    logic bypass;
    logic ch_last;
    logic running;
    logic res_empty;
    logic drain_last;
  } dp_stat_t;

endpackage

// File: hdl/rlsp_ram.sv
module rlsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/rlsp_div.sv
module rlsp_div #(
  parameter int DW = 31
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [DW-1:0]             dividend,
  input  logic [rlsp_pkg::MS_W-1:0] divisor,
  output logic                      done,
  output logic [DW-1:0]             quotient
);

  localparam int CW = $clog2(DW + 1);

  logic                      busy_r;
  logic                      done_r;
  logic [CW-1:0]             cnt_r;
  logic [DW-1:0]             dvd_r;
  logic [rlsp_pkg::MS_W-1:0] rem_r;
  logic [rlsp_pkg::MS_W-1:0] dvs_r;
  logic [rlsp_pkg::MS_W:0]   rem_sh;
  logic [rlsp_pkg::MS_W:0]   diff;
  logic                      ge;

  // restoring division, one quotient bit per cycle shifted into the dividend
  assign rem_sh = {rem_r, dvd_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], ge};
      rem_r <= ge ? diff[rlsp_pkg::MS_W-1:0] : rem_sh[rlsp_pkg::MS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// File: hdl/rlsp_datapath.sv
module rlsp_datapath #(
  parameter int PROGRAM_DEPTH       = 64,
  parameter int LEVEL_FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rlsp_pkg::ctrl_cmd_t          cmd,
  output rlsp_pkg::dp_stat_t           stat,
  input  logic [rlsp_pkg::ADDR_W-1:0]  in_address,
  input  logic [rlsp_pkg::OP_W-1:0]    in_opcode,
  input  logic [rlsp_pkg::PCT_W-1:0]   in_red_target,
  input  logic [rlsp_pkg::PCT_W-1:0]   in_green_target,
  input  logic [rlsp_pkg::PCT_W-1:0]   in_blue_target,
  input  logic [rlsp_pkg::MS_W-1:0]    in_duration_ms,
  input  logic [rlsp_pkg::MS_W-1:0]    in_step_ms,
  output logic [rlsp_pkg::LEVEL_W-1:0] out_red_level,
  output logic [rlsp_pkg::LEVEL_W-1:0] out_green_level,
  output logic [rlsp_pkg::LEVEL_W-1:0] out_blue_level,
  output logic                         out_still_running,
  output logic                         out_guard_halted,
  output logic                         out_last_of_item
);

  localparam int DW  = rlsp_pkg::NUM_W + LEVEL_FRACTION_BITS;
  localparam int GCW = $clog2(PROGRAM_DEPTH + 1);
  localparam int LW  = rlsp_pkg::LEVEL_W;
  localparam int PW  = rlsp_pkg::PCT_W;
  localparam int MW  = rlsp_pkg::MS_W;

  function automatic logic [LW-1:0] pct_to_level(input logic [PW-1:0] p);
    logic [DW-1:0] t;
    t = DW'(p) << LEVEL_FRACTION_BITS;
    return t[LW-1:0];
  endfunction

  logic [rlsp_pkg::ADDR_W-1:0]    pc_r;
  logic [rlsp_pkg::ADDR_W-1:0]    seq_r;
  logic                           running_r;
  logic                           halted_r;
  logic [MW-1:0]                  wait_r;
  logic                           fade_active_r;
  logic [MW-1:0]                  idx_r;
  logic [MW-1:0]                  count_r;
  logic [MW-1:0]                  step_r;
  logic [PW-1:0]                  held_r [3];
  logic [PW-1:0]                  fade_tgt_r [3];
  logic [LW-1:0]                  level_r [3];
  logic [1:0]                     ch_r;
  logic [rlsp_pkg::NUM_W-1:0]     num_r;
  logic [GCW-1:0]                 cmd_cnt_r;
  logic [rlsp_pkg::RES_CNT_W-1:0] res_cnt_r;
  logic [rlsp_pkg::RES_AW-1:0]    rd_idx_r;

  logic [rlsp_pkg::WORD_W-1:0] word_in;
  logic [rlsp_pkg::WORD_W-1:0] word;
  logic [PW-1:0]               w_rgb [3];
  logic [MW-1:0]               w_dur;
  logic [MW-1:0]               w_stp;
  logic [MW-1:0]               nidx;
  logic [MW-1:0]               ni;
  logic [rlsp_pkg::NUM_W-1:0]  prod_a;
  logic [rlsp_pkg::NUM_W-1:0]  prod_b;
  logic [rlsp_pkg::NUM_W:0]    num_sum;
  logic                        div_start;
  logic [DW-1:0]               div_dvd;
  logic [MW-1:0]               div_dvs;
  logic                        div_done;
  logic [DW-1:0]               div_q;
  logic [rlsp_pkg::RES_W-1:0]  push_data;
  logic [rlsp_pkg::RES_W-1:0]  res_data;
  logic                        res_wr;

  assign word_in = {in_step_ms, in_duration_ms, in_blue_target, in_green_target,
                    in_red_target, in_opcode};

  rlsp_ram #(
    .WIDTH (rlsp_pkg::WORD_W),
    .DEPTH (rlsp_pkg::PROG_WORDS)
  ) u_prog (
    .clk     (clk),
    .wr_en   (cmd.prog_wr),
    .wr_addr (in_address),
    .wr_data (word_in),
    .rd_en   (cmd.fetch),
    .rd_addr (pc_r),
    .rd_data (word)
  );

  assign w_rgb[0] = word[rlsp_pkg::W_R_LSB +: PW];
  assign w_rgb[1] = word[rlsp_pkg::W_G_LSB +: PW];
  assign w_rgb[2] = word[rlsp_pkg::W_B_LSB +: PW];
  assign w_dur    = word[rlsp_pkg::W_DUR_LSB +: MW];
  assign w_stp    = word[rlsp_pkg::W_STP_LSB +: MW];

  // interpolation numerator for the current channel
  assign ni      = count_r - idx_r;
  assign prod_a  = rlsp_pkg::NUM_W'(held_r[ch_r]) * rlsp_pkg::NUM_W'(ni);
  assign prod_b  = rlsp_pkg::NUM_W'(fade_tgt_r[ch_r]) * rlsp_pkg::NUM_W'(idx_r);
  assign num_sum = {1'b0, prod_a} + {1'b0, prod_b};

  assign div_start = cmd.div_start;
  assign div_dvd   = cmd.fade_latch ? DW'(w_dur) : (DW'(num_r) << LEVEL_FRACTION_BITS);
  assign div_dvs   = cmd.fade_latch ? w_stp : count_r;

  rlsp_div #(
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (cmd.push_src)
      rlsp_pkg::PUSH_WORD:  push_data = {pct_to_level(w_rgb[2]), pct_to_level(w_rgb[1]),
                                         pct_to_level(w_rgb[0])};
      rlsp_pkg::PUSH_HELD:  push_data = {pct_to_level(held_r[2]), pct_to_level(held_r[1]),
                                         pct_to_level(held_r[0])};
      rlsp_pkg::PUSH_LEVEL: push_data = {level_r[2], level_r[1], level_r[0]};
      default:              push_data = {level_r[2], level_r[1], level_r[0]};
    endcase
  end

  // results beyond the buffer are dropped
  assign res_wr = cmd.push && !res_cnt_r[rlsp_pkg::RES_CNT_W-1];

  rlsp_ram #(
    .WIDTH (rlsp_pkg::RES_W),
    .DEPTH (rlsp_pkg::RES_MAX)
  ) u_res (
    .clk     (clk),
    .wr_en   (res_wr),
    .wr_addr (res_cnt_r[rlsp_pkg::RES_AW-1:0]),
    .wr_data (push_data),
    .rd_en   (cmd.rd_issue),
    .rd_addr (rd_idx_r),
    .rd_data (res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= '0;
      seq_r         <= '0;
      running_r     <= 1'b0;
      halted_r      <= 1'b0;
      wait_r        <= '0;
      fade_active_r <= 1'b0;
      idx_r         <= '0;
      count_r       <= '0;
      step_r        <= '0;
      held_r        <= '{default: '0};
      fade_tgt_r    <= '{default: '0};
      ch_r          <= '0;
      cmd_cnt_r     <= '0;
      res_cnt_r     <= '0;
      rd_idx_r      <= '0;
    end else begin
      if (cmd.start_seq) begin
        fade_active_r <= 1'b0;
        wait_r        <= '0;
        halted_r      <= 1'b0;
        pc_r          <= in_address;
        seq_r         <= in_address;
        running_r     <= 1'b1;
        cmd_cnt_r     <= '0;
        res_cnt_r     <= '0;
        rd_idx_r      <= '0;
      end
      if (cmd.tick_dec) begin
        halted_r  <= 1'b0;
        wait_r    <= wait_r - 1'b1;
        res_cnt_r <= '0;
        rd_idx_r  <= '0;
      end
      if (cmd.fade_adv) begin
        idx_r <= nidx;
        ch_r  <= '0;
      end
      if (cmd.fade_finish) begin
        held_r        <= fade_tgt_r;
        fade_active_r <= 1'b0;
      end
      if (cmd.seq_advance) begin
        pc_r      <= pc_r + 1'b1;
        cmd_cnt_r <= '0;
      end
      if (cmd.fetch) begin
        cmd_cnt_r <= cmd_cnt_r + 1'b1;
      end
      if (cmd.do_loop) begin
        pc_r <= seq_r;
      end
      if (cmd.load_held) begin
        held_r <= w_rgb;
      end
      if (cmd.pc_inc) begin
        pc_r <= pc_r + 1'b1;
      end
      if (cmd.set_wait_dur) begin
        wait_r <= w_dur;
      end
      if (cmd.set_halt) begin
        running_r <= 1'b0;
        halted_r  <= 1'b1;
      end
      if (cmd.set_stop) begin
        running_r <= 1'b0;
      end
      if (cmd.fade_latch) begin
        fade_tgt_r <= w_rgb;
        step_r     <= w_stp;
      end
      if (cmd.cnt_load) begin
        count_r       <= div_q[MW-1:0];
        idx_r         <= '0;
        fade_active_r <= 1'b1;
        ch_r          <= '0;
      end
      if (cmd.ch_inc) begin
        ch_r <= ch_r + 1'b1;
      end
      if (cmd.set_wait_step) begin
        wait_r <= step_r;
      end
      if (res_wr) begin
        res_cnt_r <= res_cnt_r + 1'b1;
      end
      if (cmd.rd_adv) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fp_mul) begin
      num_r <= num_sum[rlsp_pkg::NUM_W-1:0];
    end
    if (cmd.level_bypass) begin
      level_r[ch_r] <= pct_to_level(fade_tgt_r[ch_r]);
    end
    if (cmd.level_div) begin
      level_r[ch_r] <= div_q[LW-1:0];
    end
  end

  assign nidx = idx_r + 1'b1;

  assign stat.tick_hit    = running_r && (wait_r != '0);
  assign stat.wait_one    = wait_r == MW'(1);
  assign stat.fade_active = fade_active_r;
  assign stat.fade_more   = (nidx != '0) && (nidx <= count_r);
  assign stat.guard_hit   = cmd_cnt_r >= GCW'(PROGRAM_DEPTH);
  assign stat.op          = rlsp_pkg::op_t'(word[rlsp_pkg::OP_W-1:0]);
  assign stat.dur_zero    = w_dur == '0;
  assign stat.stp_zero    = w_stp == '0;
  assign stat.div_done    = div_done;
  assign stat.bypass      = (count_r == '0) || (idx_r >= count_r);
  assign stat.ch_last     = ch_r == 2'd2;
  assign stat.running     = running_r;
  assign stat.res_empty   = res_cnt_r == '0;
  assign stat.drain_last  = ({1'b0, rd_idx_r} + 1'b1) == res_cnt_r;

  assign out_red_level     = res_data[0 +: LW];
  assign out_green_level   = res_data[LW +: LW];
  assign out_blue_level    = res_data[2*LW +: LW];
  assign out_still_running = running_r;
  assign out_guard_halted  = halted_r;
  assign out_last_of_item  = stat.drain_last;

`ifndef SYNTHESIS
  a_fetch_under_guard: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch |-> cmd_cnt_r < GCW'(PROGRAM_DEPTH))
    else $error("command fetched past the guard limit");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_seq |=> (res_cnt_r == '0) && running_r && !halted_r)
    else $error("start item did not reset the engine");

  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> res_cnt_r != '0)
    else $error("result read with an empty buffer");

  a_halt_stops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_halt |=> !running_r && halted_r)
    else $error("guard halt did not stop the engine");
`endif

endmodule

// File: hdl/rlsp_ctrl.sv
module rlsp_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rlsp_pkg::CMD_W-1:0]       in_command,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rlsp_pkg::ctrl_cmd_t              cmd,
  input  rlsp_pkg::dp_stat_t               stat
);

  rlsp_pkg::state_t state_r;
  rlsp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlsp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      rlsp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (rlsp_pkg::cmd_code_t'(in_command))
            rlsp_pkg::CMD_WRITE: cmd.prog_wr = 1'b1;
            rlsp_pkg::CMD_START: begin
              cmd.start_seq = 1'b1;
              state_nxt     = rlsp_pkg::S_FETCH;
            end
            rlsp_pkg::CMD_TICK: begin
              if (stat.tick_hit) begin
                cmd.tick_dec = 1'b1;
                if (stat.wait_one) begin
                  state_nxt = rlsp_pkg::S_RESUME;
                end
              end
            end
            default: ;
          endcase
        end
      end
      rlsp_pkg::S_RESUME: begin
        if (stat.fade_active) begin
          if (stat.fade_more) begin
            cmd.fade_adv = 1'b1;
            state_nxt    = rlsp_pkg::S_FP_MUL;
          end else begin
            cmd.fade_finish = 1'b1;
            cmd.seq_advance = 1'b1;
            state_nxt       = rlsp_pkg::S_FETCH;
          end
        end else begin
          cmd.seq_advance = 1'b1;
          state_nxt       = rlsp_pkg::S_FETCH;
        end
      end
      rlsp_pkg::S_FETCH: begin
        if (stat.guard_hit) begin
          cmd.set_halt = 1'b1;
          state_nxt    = rlsp_pkg::S_FINISH;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = rlsp_pkg::S_DECODE;
        end
      end
      rlsp_pkg::S_DECODE: begin
        state_nxt = rlsp_pkg::S_FETCH;
        case (stat.op)
          rlsp_pkg::OP_LOOP: cmd.do_loop = 1'b1;
          rlsp_pkg::OP_SET: begin
            cmd.load_held = 1'b1;
            cmd.push      = 1'b1;
            cmd.push_src  = rlsp_pkg::PUSH_WORD;
            cmd.pc_inc    = 1'b1;
          end
          rlsp_pkg::OP_DELAY: begin
            if (stat.dur_zero) begin
              cmd.pc_inc = 1'b1;
            end else begin
              cmd.set_wait_dur = 1'b1;
              state_nxt        = rlsp_pkg::S_FINISH;
            end
          end
          rlsp_pkg::OP_FADE: begin
            if (stat.stp_zero) begin
              cmd.load_held = 1'b1;
              cmd.push      = 1'b1;
              cmd.push_src  = rlsp_pkg::PUSH_WORD;
              cmd.pc_inc    = 1'b1;
            end else begin
              cmd.fade_latch = 1'b1;
              cmd.div_start  = 1'b1;
              state_nxt      = rlsp_pkg::S_CNT_DIV;
            end
          end
          default: begin
            // end and unknown opcodes stop the sequence
            cmd.set_stop = 1'b1;
            state_nxt    = rlsp_pkg::S_FINISH;
          end
        endcase
      end
      rlsp_pkg::S_CNT_DIV: begin
        if (stat.div_done) begin
          cmd.cnt_load = 1'b1;
          state_nxt    = rlsp_pkg::S_FP_MUL;
        end
      end
      rlsp_pkg::S_FP_MUL: begin
        cmd.fp_mul = 1'b1;
        state_nxt  = rlsp_pkg::S_FP_DIV;
      end
      rlsp_pkg::S_FP_DIV: begin
        if (stat.bypass) begin
          cmd.level_bypass = 1'b1;
          state_nxt        = rlsp_pkg::S_FP_NEXT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = rlsp_pkg::S_FP_WAIT;
        end
      end
      rlsp_pkg::S_FP_WAIT: begin
        if (stat.div_done) begin
          cmd.level_div = 1'b1;
          state_nxt     = rlsp_pkg::S_FP_NEXT;
        end
      end
      rlsp_pkg::S_FP_NEXT: begin
        if (stat.ch_last) begin
          cmd.push          = 1'b1;
          cmd.push_src      = rlsp_pkg::PUSH_LEVEL;
          cmd.set_wait_step = 1'b1;
          state_nxt         = rlsp_pkg::S_FINISH;
        end else begin
          cmd.ch_inc = 1'b1;
          state_nxt  = rlsp_pkg::S_FP_MUL;
        end
      end
      rlsp_pkg::S_FINISH: begin
        if (stat.res_empty && !stat.running) begin
          // stopped without a colour: report the held colour once
          cmd.push     = 1'b1;
          cmd.push_src = rlsp_pkg::PUSH_HELD;
          state_nxt    = rlsp_pkg::S_DR_READ;
        end else if (stat.res_empty) begin
          state_nxt = rlsp_pkg::S_IDLE;
        end else begin
          state_nxt = rlsp_pkg::S_DR_READ;
        end
      end
      rlsp_pkg::S_DR_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = rlsp_pkg::S_DR_OUT;
      end
      rlsp_pkg::S_DR_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.drain_last) begin
            state_nxt = rlsp_pkg::S_IDLE;
          end else begin
            cmd.rd_adv = 1'b1;
            state_nxt  = rlsp_pkg::S_DR_READ;
          end
        end
      end
      default: state_nxt = rlsp_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_out_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !stat.res_empty)
    else $error("result offered from an empty buffer");

  a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid && (state_r == rlsp_pkg::S_IDLE))
    else $error("input taken while an item is in progress");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && stat.drain_last |=> state_r == rlsp_pkg::S_IDLE)
    else $error("engine did not return to idle after the last result");
`endif

endmodule

// File: hdl/rgb_led_sequence_player_core.sv
// RGB LED pattern engine.
// Input channel (in_*): one item is a program word write, a start at an
// address, or a one-millisecond tick. Result channel (out_*): one item per
// colour update, up to 64 per input item, the final one flagged by
// out_last_of_item; still_running and guard_halted hold the engine state at
// the end of the input item.
// Items are handled one at a time. A start or a tick that resumes the
// program walks commands one at a time through the program memory read
// port; a fade point uses the shared bit-serial divider for each channel
// that is not bypassed, and the first fade point of a fade also uses it
// for its step count. Results are collected in a buffer and then sent one
// by one, each read from the buffer before it is offered; in_ready stays
// low until the last result is taken, so a stalled receiver holds the
// whole engine.
// After reset the engine is idle with colour zero; program words are
// undefined until written.
module rgb_led_sequence_player_core #(
  parameter int PROGRAM_DEPTH       = 64,
  parameter int LEVEL_FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rlsp_pkg::CMD_W-1:0]   in_command,
  input  logic [rlsp_pkg::ADDR_W-1:0]  in_address,
  input  logic [rlsp_pkg::OP_W-1:0]    in_opcode,
  input  logic [rlsp_pkg::PCT_W-1:0]   in_red_target,
  input  logic [rlsp_pkg::PCT_W-1:0]   in_green_target,
  input  logic [rlsp_pkg::PCT_W-1:0]   in_blue_target,
  input  logic [rlsp_pkg::MS_W-1:0]    in_duration_ms,
  input  logic [rlsp_pkg::MS_W-1:0]    in_step_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rlsp_pkg::LEVEL_W-1:0] out_red_level,
  output logic [rlsp_pkg::LEVEL_W-1:0] out_green_level,
  output logic [rlsp_pkg::LEVEL_W-1:0] out_blue_level,
  output logic                         out_still_running,
  output logic                         out_guard_halted,
  output logic                         out_last_of_item
);

  rlsp_pkg::ctrl_cmd_t cmd;
  rlsp_pkg::dp_stat_t  stat;

  rlsp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  rlsp_datapath #(
    .PROGRAM_DEPTH       (PROGRAM_DEPTH),
    .LEVEL_FRACTION_BITS (LEVEL_FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_address        (in_address),
    .in_opcode         (in_opcode),
    .in_red_target     (in_red_target),
    .in_green_target   (in_green_target),
    .in_blue_target    (in_blue_target),
    .in_duration_ms    (in_duration_ms),
    .in_step_ms        (in_step_ms),
    .out_red_level     (out_red_level),
    .out_green_level   (out_green_level),
    .out_blue_level    (out_blue_level),
    .out_still_running (out_still_running),
    .out_guard_halted  (out_guard_halted),
    .out_last_of_item  (out_last_of_item)
  );

endmodule
